[rtl/tcst_pkg.sv]
// Shared types, constants and coefficient table for the cosine/sine/tangent block.
`timescale 1ns / 1ps

package tcst_pkg;

    // Default and largest number of Taylor terms.
    localparam int TERMS_DEF = 6;
    localparam int TERMS_MAX = 10;

    // Datapath widths: reduction argument, remainder, Q28 x, Q28 x squared, Horner value.
    localparam int ARG_W = 39;
    localparam int R_W   = 35;
    localparam int X_W   = 30;
    localparam int Y_W   = 32;
    localparam int T_W   = 32;

    // Width of the tangent divisor, and the number of quotient bits the divider makes.
    localparam int D_W       = 30;
    localparam int DIV_STEPS = 32;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Angle constants in Q32.
    localparam logic [ARG_W-1:0] TWO_PI_Q32  = 39'd26986075409;
    localparam logic [ARG_W-1:0] PI_Q32      = 39'd13493037705;
    localparam logic [ARG_W-1:0] HALF_PI_Q32 = 39'd6746518852;

    // Smallest cosine magnitude used as a tangent divisor (0.0001 in Q28).
    localparam logic [D_W-1:0] TAN_FLOOR_Q28 = 30'd26844;

    // Even Taylor coefficients (-1)^k / (2k)! in Q28, rounded to nearest.
    localparam logic signed [T_W-1:0] COEF [TERMS_MAX] = '{
        32'sd268435456,
        -32'sd134217728,
        32'sd11184811,
        -32'sd372827,
        32'sd6658,
        -32'sd74,
        32'sd1,
        32'sd0,
        32'sd0,
        32'sd0
    };

    // Function select.
    typedef enum logic [1:0] {
        CMD_COS  = 2'd0,
        CMD_SIN  = 2'd1,
        CMD_TAN  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // One classified beat handed from the front to the back.
    typedef struct packed {
        cmd_t                    cmd;
        logic signed [ARG_W-1:0] arg_cos;
        logic signed [ARG_W-1:0] arg_sin;
    } item_t;

endpackage

[rtl/tcst_queue.sv]
// Small flop-based queue between the front and the back.
`timescale 1ns / 1ps

module tcst_queue
    import tcst_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    // Handshake and read side.
    assign ready   = (cnt_reg != CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    // Pointer and count update, with explicit wrap.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    // The fill count never passes the depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // The front only pushes when there is room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("push into a full queue");

    // A push with no pop raises the count by one.
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

[rtl/tcst_front.sv]
// Front part: takes input beats, classifies them and forms both reduction arguments.
`timescale 1ns / 1ps

module tcst_front
    import tcst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic signed [31:0] angle,
    input  logic        q_ready,
    output logic        q_push,
    output item_t       q_item
);

    logic               v_reg, v_next;
    cmd_t               cmd_reg;
    logic signed [31:0] ang_reg;
    logic               take;
    logic signed [ARG_W-1:0] a_q32;

    // The input stage is free when empty or when its beat moves on this cycle.
    assign full   = v_reg && !q_ready;
    assign take   = push && !full;
    assign q_push = v_reg && q_ready;

    // Angle times 64 puts Q6.26 into Q32; sine uses pi/2 minus the angle.
    assign a_q32          = {ang_reg[31], ang_reg, 6'b0};
    assign q_item.cmd     = cmd_reg;
    assign q_item.arg_cos = a_q32;
    assign q_item.arg_sin = $signed(HALF_PI_Q32) - a_q32;

    always_comb
    begin
        v_next = v_reg;
        if (take)
        begin
            v_next = 1'b1;
        end
        else if (q_push)
        begin
            v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_t'(cmd);
            ang_reg <= angle;
        end
    end

endmodule

[rtl/tcst_cos.sv]
// Pipelined cosine: modulo 2*pi reduction, fold to [0, pi], Horner Taylor sum in Q28.
`timescale 1ns / 1ps

module tcst_cos
    import tcst_pkg::*;
#(
    parameter int TERMS = TERMS_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ARG_W-1:0] arg,
    output logic signed [T_W-1:0]   cos_q28
);

    localparam int STEPS = TERMS - 1;

    // Reduction stages: magnitude, then three compare-subtracts of 2*pi scaled by 4, 2, 1.
    logic [ARG_W-1:0] red_reg [4];
    logic             rneg_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg[0]  <= arg[ARG_W-1] ? ARG_W'(-arg) : ARG_W'(arg);
            rneg_reg[0] <= arg[ARG_W-1];
        end
    end

    for (genvar g = 1; g < 4; g++)
    begin : g_red
        localparam logic [ARG_W-1:0] STEP = TWO_PI_Q32 << (3 - g);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                red_reg[g]  <= (red_reg[g-1] >= STEP) ? red_reg[g-1] - STEP : red_reg[g-1];
                rneg_reg[g] <= rneg_reg[g-1];
            end
        end
    end

    // A negative remainder gets 2*pi added, then values above pi are folded.
    logic [R_W-1:0] rem_w;
    logic [R_W-1:0] r_reg;
    logic [R_W-1:0] f_reg;
    logic           fneg_reg;
    logic [R_W:0]   f_rnd;
    logic [X_W-1:0] x_reg;
    logic           xneg_reg;
    logic [2*X_W-1:0] xx_reg;
    logic           xxneg_reg;
    logic [2*X_W:0] xx_rnd;
    logic [Y_W-1:0] y_reg;
    logic           yneg_reg;

    assign rem_w  = red_reg[3][R_W-1:0];
    assign f_rnd  = {1'b0, f_reg} + (R_W+1)'(8);
    assign xx_rnd = {1'b0, xx_reg} + (2*X_W+1)'(1 << 27);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= (rneg_reg[3] && rem_w != '0) ? TWO_PI_Q32[R_W-1:0] - rem_w : rem_w;
            f_reg     <= (r_reg > PI_Q32[R_W-1:0]) ? r_reg - PI_Q32[R_W-1:0] : r_reg;
            fneg_reg  <= (r_reg > PI_Q32[R_W-1:0]);
            x_reg     <= f_rnd[X_W+3:4];
            xneg_reg  <= fneg_reg;
            xx_reg    <= (2*X_W)'(x_reg) * (2*X_W)'(x_reg);
            xxneg_reg <= xneg_reg;
            y_reg     <= xx_rnd[28+Y_W-1:28];
            yneg_reg  <= xxneg_reg;
        end
    end

    // Horner steps: a multiply stage, then a round-and-add stage.
    logic signed [T_W-1:0] t_in  [STEPS];
    logic [Y_W-1:0]        y_in  [STEPS];
    logic                  n_in  [STEPS];
    logic [63:0]           p_reg [STEPS];
    logic                  ps_reg [STEPS];
    logic [Y_W-1:0]        ya_reg [STEPS];
    logic                  na_reg [STEPS];
    logic signed [T_W-1:0] t_reg [STEPS];
    logic [Y_W-1:0]        yb_reg [STEPS];
    logic                  nb_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_horner
        localparam int K = TERMS - 2 - i;
        logic [T_W-1:0]        tm;
        logic [64:0]           p_rnd;
        logic [36:0]           pr;
        logic signed [37:0]    ps_val;
        logic signed [37:0]    coef_ext;

        if (i == 0)
        begin : g_first
            assign t_in[i] = COEF[TERMS-1];
            assign y_in[i] = y_reg;
            assign n_in[i] = yneg_reg;
        end
        else
        begin : g_next
            assign t_in[i] = t_reg[i-1];
            assign y_in[i] = yb_reg[i-1];
            assign n_in[i] = nb_reg[i-1];
        end

        assign tm       = t_in[i][T_W-1] ? T_W'(-t_in[i]) : T_W'(t_in[i]);
        assign p_rnd    = {1'b0, p_reg[i]} + 65'(1 << 27);
        assign pr       = p_rnd[64:28];
        assign ps_val   = ps_reg[i] ? -$signed({1'b0, pr}) : $signed({1'b0, pr});
        assign coef_ext = 38'(COEF[K]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[i]  <= 64'(tm) * 64'(y_in[i]);
                ps_reg[i] <= t_in[i][T_W-1];
                ya_reg[i] <= y_in[i];
                na_reg[i] <= n_in[i];
                t_reg[i]  <= T_W'(ps_val + coef_ext);
                yb_reg[i] <= ya_reg[i];
                nb_reg[i] <= na_reg[i];
            end
        end
    end

    // Sign from the fold.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_q28 <= nb_reg[STEPS-1] ? -t_reg[STEPS-1] : t_reg[STEPS-1];
        end
    end

endmodule

[rtl/tcst_back.sv]
// Back part: cosine and sine evaluators, tangent divider and the output register.
`timescale 1ns / 1ps

module tcst_back
    import tcst_pkg::*;
#(
    parameter int TERMS = TERMS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  item_t              in_item,
    output logic               in_ready,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] value
);

    // Stages in one cosine evaluator: 9 for reduction and squaring, 2 per Horner step, 1 out.
    localparam int COS_LAT = 2 * TERMS + 8;

    logic en;
    logic take;
    logic out_v_reg;
    cmd_t out_cmd_reg;
    logic signed [31:0] value_reg;

    // The whole pipeline moves when the output register is free or being popped.
    assign en       = !out_v_reg || pop;
    assign in_ready = en;
    assign take     = in_valid && en;
    assign empty    = !out_v_reg;
    assign value    = value_reg;

    // Both evaluators run on every beat.
    logic signed [T_W-1:0] c_q28;
    logic signed [T_W-1:0] s_q28;

    tcst_cos #(.TERMS(TERMS)) u_cos (
        .clk     (clk),
        .en      (en),
        .arg     (in_item.arg_cos),
        .cos_q28 (c_q28)
    );

    tcst_cos #(.TERMS(TERMS)) u_sin (
        .clk     (clk),
        .en      (en),
        .arg     (in_item.arg_sin),
        .cos_q28 (s_q28)
    );

    // Valid and command travel beside the evaluators.
    logic lv_reg [COS_LAT];
    cmd_t lc_reg [COS_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COS_LAT; i++)
            begin
                lv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            lv_reg[0] <= take;
            for (int i = 1; i < COS_LAT; i++)
            begin
                lv_reg[i] <= lv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lc_reg[0] <= in_item.cmd;
            for (int i = 1; i < COS_LAT; i++)
            begin
                lc_reg[i] <= lc_reg[i-1];
            end
        end
    end

    // Tangent operands and the Q16.16 cosine or sine result.
    logic [T_W-1:0]  mc_full;
    logic [T_W-1:0]  ms_full;
    logic [D_W-1:0]  mc;
    logic [D_W-1:0]  dv;
    logic            cneg;
    logic [45:0]     num;
    logic signed [T_W-1:0] sel;
    logic [T_W-1:0]  msel;
    logic [T_W:0]    msel_rnd;
    logic [20:0]     q16m;
    logic signed [31:0] pres;

    assign mc_full  = c_q28[T_W-1] ? T_W'(-c_q28) : T_W'(c_q28);
    assign ms_full  = s_q28[T_W-1] ? T_W'(-s_q28) : T_W'(s_q28);
    assign mc       = mc_full[D_W-1:0];
    assign dv       = (mc < TAN_FLOOR_Q28) ? TAN_FLOOR_Q28 : mc;
    assign cneg     = (mc < TAN_FLOOR_Q28) ? 1'b0 : c_q28[T_W-1];
    assign num      = {ms_full[D_W-1:0], 16'b0} + 46'(dv >> 1);
    assign sel      = (lc_reg[COS_LAT-1] == CMD_SIN) ? s_q28 : c_q28;
    assign msel     = sel[T_W-1] ? T_W'(-sel) : T_W'(sel);
    assign msel_rnd = {1'b0, msel} + (T_W+1)'(2048);
    assign q16m     = msel_rnd[T_W:12];
    assign pres     = sel[T_W-1] ? -$signed({11'b0, q16m}) : $signed({11'b0, q16m});

    // Divider line: one quotient bit per stage, restoring.
    logic                  dvld_reg [DIV_STEPS+1];
    cmd_t                  dcmd_reg [DIV_STEPS+1];
    logic [D_W-1:0]        rem_reg  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]  nq_reg   [DIV_STEPS+1];
    logic [D_W-1:0]        d_reg    [DIV_STEPS+1];
    logic                  tneg_reg [DIV_STEPS+1];
    logic signed [31:0]    pres_reg [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                dvld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            dvld_reg[0] <= lv_reg[COS_LAT-1];
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                dvld_reg[i] <= dvld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dcmd_reg[0] <= lc_reg[COS_LAT-1];
            rem_reg[0]  <= D_W'(num[45:DIV_STEPS]);
            nq_reg[0]   <= num[DIV_STEPS-1:0];
            d_reg[0]    <= dv;
            tneg_reg[0] <= s_q28[T_W-1] ^ cneg;
            pres_reg[0] <= (lc_reg[COS_LAT-1] == CMD_COS || lc_reg[COS_LAT-1] == CMD_SIN)
                           ? pres : '0;
        end
    end

    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_div
        logic [D_W:0] shifted;
        logic         ge;
        logic [D_W:0] diff;

        assign shifted = {rem_reg[i-1], nq_reg[i-1][DIV_STEPS-1]};
        assign ge      = (shifted >= {1'b0, d_reg[i-1]});
        assign diff    = shifted - {1'b0, d_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
                nq_reg[i]   <= {nq_reg[i-1][DIV_STEPS-2:0], ge};
                d_reg[i]    <= d_reg[i-1];
                dcmd_reg[i] <= dcmd_reg[i-1];
                tneg_reg[i] <= tneg_reg[i-1];
                pres_reg[i] <= pres_reg[i-1];
            end
        end
    end

    // Signed, saturated tangent.
    logic [31:0] q;
    logic [31:0] qn;
    logic signed [31:0] tan_val;
    logic signed [31:0] val_next;

    assign q  = nq_reg[DIV_STEPS];
    assign qn = ~q + 32'd1;

    always_comb
    begin
        if (tneg_reg[DIV_STEPS])
        begin
            tan_val = (q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(qn);
        end
        else
        begin
            tan_val = (q > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q);
        end
        case (dcmd_reg[DIV_STEPS])
            CMD_TAN:  val_next = tan_val;
            CMD_NONE: val_next = '0;
            default:  val_next = pres_reg[DIV_STEPS];
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dvld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg   <= val_next;
            out_cmd_reg <= dcmd_reg[DIV_STEPS];
        end
    end

    // A waiting result that is not popped stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !pop) |=> (out_v_reg && $stable(value_reg)))
        else $error("waiting result changed before pop");

    // The unused select always gives zero.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_cmd_reg == CMD_NONE) |-> (value_reg == '0))
        else $error("unused select gave a nonzero result");

    // A stalled output register holds off the queue.
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !pop) |-> !in_ready)
        else $error("input taken while the output is stalled");

endmodule

[rtl/taylor_cos_sin_tan_top.sv]
// Top level of the cosine/sine/tangent block: front, queue and back.
//
//   Channel   Direction  Handshake        Payload
//   input     in         push / full      cmd[1:0], angle[31:0] (Q6.26)
//   result    out        pop / empty      value[31:0] (Q16.16)
//
// One beat is accepted per cycle while full is low; every beat gives one result beat,
// in order. From push to result a beat passes the front stage, one queue slot, the
// two Taylor evaluators, the 33-stage divider line and the output register.
// Reset clears only valid bits and the queue pointers and count; there is no clearing pass.
// A result waiting on pop freezes the back pipeline; the front and queue still
// take up to three more beats before full rises.
`timescale 1ns / 1ps

module taylor_cos_sin_tan_top
    import tcst_pkg::*;
#(
    parameter int TAYLOR_TERMS = TERMS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] angle,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] value
);

    localparam int ITEM_W = $bits(item_t);

    logic              q_ready;
    logic              q_push;
    item_t             f_item;
    logic              b_valid;
    logic              b_ready;
    logic [ITEM_W-1:0] b_data;

    tcst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd     (cmd),
        .angle   (angle),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_item  (f_item)
    );

    tcst_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (f_item),
        .ready (q_ready),
        .pop   (b_ready),
        .valid (b_valid),
        .rdata (b_data)
    );

    tcst_back #(.TERMS(TAYLOR_TERMS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (b_valid),
        .in_item  (item_t'(b_data)),
        .in_ready (b_ready),
        .empty    (empty),
        .pop      (pop),
        .value    (value)
    );

endmodule
